FILE: sv/lob_pkg.sv
package lob_pkg;

    localparam int BOOK_DEPTH = 16;
    localparam int PTR_W = $clog2(BOOK_DEPTH);
    localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_CHANGE = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_MATCH  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        KIND_ADD_ACK    = 3'd0,
        KIND_CHANGE_ACK = 3'd1,
        KIND_REMOVE_ACK = 3'd2,
        KIND_TRADE      = 3'd3,
        KIND_NO_TRADE   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        side;
        logic [31:0] limit_price;
        logic [23:0] amount;
        logic [15:0] order_id;
    } request_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [1:0]  status;
        logic [15:0] assigned_id;
        logic [15:0] buy_id;
        logic [15:0] sell_id;
        logic [23:0] traded_amount;
        logic        last;
    } result_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]  mode;
        logic        bid_book;
        logic [31:0] limit_price;
        logic [23:0] amount;
        logic [15:0] order_id;
    } command_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_MATCH,
        ST_EMIT
    } state_t;

endpackage

FILE: sv/lob_if.sv
interface lob_req_if;
    logic               valid;
    logic               ready;
    lob_pkg::request_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lob_res_if;
    logic               valid;
    logic               ready;
    lob_pkg::result_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/lob_front.sv
module lob_front (
    input  logic                  clk,
    input  logic                  rst_n,
    lob_req_if.sink               req,
    output logic                  cmd_valid,
    output lob_pkg::command_t     cmd,
    input  logic                  cmd_ready
);

    lob_pkg::command_t          q_reg [lob_pkg::QUEUE_DEPTH];
    logic                       wr_reg, wr_next;
    logic                       rd_reg, rd_next;
    logic [1:0]                 fill_reg, fill_next;
    lob_pkg::command_t          classified;
    logic                       push;
    logic                       pop;

    always_comb
    begin
        classified.mode        = req.payload.mode;
        classified.limit_price = req.payload.limit_price;
        classified.amount      = req.payload.amount;
        classified.order_id    = req.payload.order_id;
        if (req.payload.mode == lob_pkg::MODE_ADD)
            classified.bid_book = req.payload.side;
        else
            classified.bid_book = ~req.payload.order_id[0];
    end

    assign req.ready = (fill_reg != 2'(lob_pkg::QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        wr_next   = push ? ~wr_reg : wr_reg;
        rd_next   = pop ? ~rd_reg : rd_reg;
        fill_next = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= classified;
    end

endmodule

FILE: sv/lob_back.sv
module lob_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  lob_pkg::command_t     cmd,
    output logic                  cmd_ready,
    lob_res_if.source             res
);

    localparam int D = lob_pkg::BOOK_DEPTH;
    localparam int PW = lob_pkg::PTR_W;
    localparam int CW = lob_pkg::CNT_W;

    logic [31:0] bp_reg [D];
    logic [23:0] bq_reg [D];
    logic [15:0] bi_reg [D];
    logic [31:0] ap_reg [D];
    logic [23:0] aq_reg [D];
    logic [15:0] ai_reg [D];
    logic [CW-1:0] bcnt_reg, bcnt_next;
    logic [CW-1:0] acnt_reg, acnt_next;
    logic [15:0] lbuy_reg, lbuy_next;
    logic [15:0] lsell_reg, lsell_next;

    lob_pkg::state_t    state_reg, state_next;
    lob_pkg::command_t  cur_reg, cur_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [15:0]        nid_reg, nid_next;
    logic               out_valid_reg, out_valid_next;
    lob_pkg::result_t   out_reg, out_next;
    lob_pkg::result_t   pend_reg, pend_next;

    // shift and write command for one book side, plus front pops and quantity updates
    logic               wr_en;
    logic               wr_bid;
    logic               wr_shift_up;
    logic               wr_shift_down;
    logic [PW-1:0]      wr_idx;
    logic [31:0]        wr_price;
    logic [23:0]        wr_qty;
    logic [15:0]        wr_id;
    logic               pop_bid, pop_ask;
    logic               setq_bid, setq_ask;
    logic [23:0]        setq_val;

    // book fronts as they stand after the current trade
    logic [CW-1:0]      bcnt_left, acnt_left;
    logic [31:0]        bpx_left, apx_left;
    logic               more_trade;

    logic [CW-1:0]      cnt_cur;
    logic [PW-1:0]      idx_p;
    logic [31:0]        price_at;
    logic [15:0]        id_at;
    logic               bid_sel;
    logic               out_free;

    assign res.valid   = out_valid_reg;
    assign res.payload = out_reg;
    assign out_free    = !out_valid_reg || res.ready;
    assign bid_sel     = cur_reg.bid_book;
    assign cnt_cur     = bid_sel ? bcnt_reg : acnt_reg;
    assign idx_p       = idx_reg[PW-1:0];
    assign price_at    = bid_sel ? bp_reg[idx_p] : ap_reg[idx_p];
    assign id_at       = bid_sel ? bi_reg[idx_p] : ai_reg[idx_p];

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        nid_next       = nid_reg;
        bcnt_next      = bcnt_reg;
        acnt_next      = acnt_reg;
        lbuy_next      = lbuy_reg;
        lsell_next     = lsell_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next       = out_reg;
        pend_next      = pend_reg;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;
        wr_bid         = bid_sel;
        wr_shift_up    = 1'b0;
        wr_shift_down  = 1'b0;
        wr_idx         = pos_reg[PW-1:0];
        wr_price       = cur_reg.limit_price;
        wr_qty         = cur_reg.amount;
        wr_id          = nid_reg;
        pop_bid        = 1'b0;
        pop_ask        = 1'b0;
        setq_bid       = 1'b0;
        setq_ask       = 1'b0;
        setq_val       = '0;
        bcnt_left      = bcnt_reg;
        acnt_left      = acnt_reg;
        bpx_left       = bp_reg[0];
        apx_left       = ap_reg[0];
        more_trade     = 1'b0;
        case (state_reg)
            lob_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cur_next    = cmd;
                    idx_next    = '0;
                    if (cmd.mode == lob_pkg::MODE_MATCH)
                        state_next = lob_pkg::ST_MATCH;
                    else
                        state_next = lob_pkg::ST_SCAN;
                    if (cmd.mode == lob_pkg::MODE_ADD)
                        pos_next = cmd.bid_book ? bcnt_reg : acnt_reg;
                end
            end
            lob_pkg::ST_SCAN:
            begin
                if (cur_reg.mode == lob_pkg::MODE_ADD)
                begin
                    if (cnt_cur >= CW'(D))
                    begin
                        pend_next = '0;
                        pend_next.kind   = lob_pkg::KIND_ADD_ACK;
                        pend_next.status = lob_pkg::STATUS_FULL;
                        pend_next.last   = 1'b1;
                        state_next = lob_pkg::ST_EMIT;
                    end
                    else if (idx_reg < cnt_cur &&
                             !(bid_sel ? (cur_reg.limit_price > price_at)
                                       : (cur_reg.limit_price < price_at)))
                        idx_next = idx_reg + CW'(1);
                    else
                    begin
                        pos_next = idx_reg;
                        if (bid_sel)
                        begin
                            lbuy_next = lbuy_reg + 16'd2;
                            nid_next  = lbuy_reg + 16'd2;
                        end
                        else
                        begin
                            lsell_next = lsell_reg + 16'd2;
                            nid_next   = lsell_reg + 16'd2;
                        end
                        idx_next   = cnt_cur;
                        state_next = lob_pkg::ST_SHIFT;
                    end
                end
                else
                begin
                    if (idx_reg >= cnt_cur)
                    begin
                        pend_next = '0;
                        pend_next.kind   = {1'b0, cur_reg.mode};
                        pend_next.status = lob_pkg::STATUS_NOT_FOUND;
                        pend_next.last   = 1'b1;
                        state_next = lob_pkg::ST_EMIT;
                    end
                    else if (id_at == cur_reg.order_id)
                    begin
                        pend_next = '0;
                        pend_next.kind = {1'b0, cur_reg.mode};
                        pend_next.last = 1'b1;
                        if (cur_reg.mode == lob_pkg::MODE_CHANGE)
                        begin
                            wr_en    = 1'b1;
                            wr_idx   = idx_p;
                            wr_price = price_at;
                            wr_id    = id_at;
                            state_next = lob_pkg::ST_EMIT;
                        end
                        else
                        begin
                            pos_next   = idx_reg;
                            state_next = lob_pkg::ST_SHIFT;
                        end
                    end
                    else
                        idx_next = idx_reg + CW'(1);
                end
            end
            lob_pkg::ST_SHIFT:
            begin
                if (cur_reg.mode == lob_pkg::MODE_ADD)
                begin
                    // one entry moved up per cycle, then the new order written
                    if (idx_reg > pos_reg)
                    begin
                        wr_shift_up = 1'b1;
                        wr_idx      = idx_p;
                        idx_next    = idx_reg - CW'(1);
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (bid_sel)
                            bcnt_next = bcnt_reg + CW'(1);
                        else
                            acnt_next = acnt_reg + CW'(1);
                        pend_next = '0;
                        pend_next.kind        = lob_pkg::KIND_ADD_ACK;
                        pend_next.assigned_id = nid_reg;
                        pend_next.last        = 1'b1;
                        state_next = lob_pkg::ST_EMIT;
                    end
                end
                else
                begin
                    if (pos_reg + CW'(1) < cnt_cur)
                    begin
                        wr_shift_down = 1'b1;
                        wr_idx        = pos_reg[PW-1:0];
                        pos_next      = pos_reg + CW'(1);
                    end
                    else
                    begin
                        if (bid_sel)
                            bcnt_next = bcnt_reg - CW'(1);
                        else
                            acnt_next = acnt_reg - CW'(1);
                        state_next = lob_pkg::ST_EMIT;
                    end
                end
            end
            lob_pkg::ST_MATCH:
            begin
                if (out_free)
                begin
                    if (bcnt_reg != '0 && acnt_reg != '0 && bp_reg[0] >= ap_reg[0])
                    begin
                        out_valid_next        = 1'b1;
                        out_next              = '0;
                        out_next.kind         = lob_pkg::KIND_TRADE;
                        out_next.buy_id       = bi_reg[0];
                        out_next.sell_id      = ai_reg[0];
                        out_next.traded_amount = (bq_reg[0] < aq_reg[0]) ? bq_reg[0]
                                                                         : aq_reg[0];
                        if (bq_reg[0] > aq_reg[0])
                        begin
                            setq_bid = 1'b1;
                            setq_val = bq_reg[0] - aq_reg[0];
                            pop_ask  = 1'b1;
                        end
                        else if (aq_reg[0] > bq_reg[0])
                        begin
                            setq_ask = 1'b1;
                            setq_val = aq_reg[0] - bq_reg[0];
                            pop_bid  = 1'b1;
                        end
                        else
                        begin
                            pop_bid = 1'b1;
                            pop_ask = 1'b1;
                        end
                        // look ahead at the fronts left behind to set last
                        bcnt_left  = bcnt_reg - CW'(pop_bid);
                        acnt_left  = acnt_reg - CW'(pop_ask);
                        bpx_left   = pop_bid ? bp_reg[1] : bp_reg[0];
                        apx_left   = pop_ask ? ap_reg[1] : ap_reg[0];
                        more_trade = (bcnt_left != '0) && (acnt_left != '0) &&
                                     (bpx_left >= apx_left);
                        out_next.last = !more_trade;
                        bcnt_next     = bcnt_left;
                        acnt_next     = acnt_left;
                        state_next    = more_trade ? lob_pkg::ST_MATCH : lob_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pend_next = '0;
                        pend_next.kind = lob_pkg::KIND_NO_TRADE;
                        pend_next.last = 1'b1;
                        state_next = lob_pkg::ST_EMIT;
                    end
                end
            end
            lob_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    state_next     = lob_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lob_pkg::ST_IDLE;
        endcase
    end

    // book storage: add and remove shifts, writes, quantity updates and match pops
    always_ff @(posedge clk)
    begin
        if (wr_shift_up)
        begin
            if (wr_bid)
            begin
                bp_reg[wr_idx] <= bp_reg[wr_idx - PW'(1)];
                bq_reg[wr_idx] <= bq_reg[wr_idx - PW'(1)];
                bi_reg[wr_idx] <= bi_reg[wr_idx - PW'(1)];
            end
            else
            begin
                ap_reg[wr_idx] <= ap_reg[wr_idx - PW'(1)];
                aq_reg[wr_idx] <= aq_reg[wr_idx - PW'(1)];
                ai_reg[wr_idx] <= ai_reg[wr_idx - PW'(1)];
            end
        end
        if (wr_shift_down)
        begin
            if (wr_bid)
            begin
                bp_reg[wr_idx] <= bp_reg[wr_idx + PW'(1)];
                bq_reg[wr_idx] <= bq_reg[wr_idx + PW'(1)];
                bi_reg[wr_idx] <= bi_reg[wr_idx + PW'(1)];
            end
            else
            begin
                ap_reg[wr_idx] <= ap_reg[wr_idx + PW'(1)];
                aq_reg[wr_idx] <= aq_reg[wr_idx + PW'(1)];
                ai_reg[wr_idx] <= ai_reg[wr_idx + PW'(1)];
            end
        end
        if (wr_en)
        begin
            if (wr_bid)
            begin
                bp_reg[wr_idx] <= wr_price;
                bq_reg[wr_idx] <= wr_qty;
                bi_reg[wr_idx] <= wr_id;
            end
            else
            begin
                ap_reg[wr_idx] <= wr_price;
                aq_reg[wr_idx] <= wr_qty;
                ai_reg[wr_idx] <= wr_id;
            end
        end
        if (setq_bid)
            bq_reg[0] <= setq_val;
        if (setq_ask)
            aq_reg[0] <= setq_val;
        if (pop_bid)
        begin
            for (int i = 0; i < D - 1; i++)
            begin
                bp_reg[i] <= bp_reg[i + 1];
                bq_reg[i] <= bq_reg[i + 1];
                bi_reg[i] <= bi_reg[i + 1];
            end
        end
        if (pop_ask)
        begin
            for (int i = 0; i < D - 1; i++)
            begin
                ap_reg[i] <= ap_reg[i + 1];
                aq_reg[i] <= aq_reg[i + 1];
                ai_reg[i] <= ai_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lob_pkg::ST_IDLE;
            bcnt_reg      <= '0;
            acnt_reg      <= '0;
            lbuy_reg      <= 16'd0;
            lsell_reg     <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bcnt_reg      <= bcnt_next;
            acnt_reg      <= acnt_next;
            lbuy_reg      <= lbuy_next;
            lsell_reg     <= lsell_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        nid_reg  <= nid_next;
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

endmodule

FILE: sv/limit_order_book_matcher.sv
// add, change and remove: front queue, IDLE, SCAN, SHIFT (add and remove only), EMIT
// match: trades leave from MATCH, one per cycle unless res stalls; no trade goes via EMIT
// back end: one request at a time, paced by the one-entry-per-cycle book walk;
// a match holds it until its trades are out and the books no longer cross
// reset: async active low, resets counts, id counters and queue; book entries stay undefined
module limit_order_book_matcher (
    input  logic       clk,
    input  logic       rst_n,
    lob_req_if.sink    req,
    lob_res_if.source  res
);

    logic               cmd_valid;
    logic               cmd_ready;
    lob_pkg::command_t  cmd;

    lob_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    lob_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .res       (res)
    );

endmodule

FILE: sv/lob_checker.sv
module lob_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              res_valid,
    input logic              res_ready,
    input lob_pkg::result_t  res_payload
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_payload))
        else $error("result changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_payload.kind <= lob_pkg::KIND_NO_TRADE)
        else $error("bad result kind");

    a_trade_ids: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_payload.kind == lob_pkg::KIND_TRADE |->
        !res_payload.buy_id[0] && res_payload.sell_id[0])
        else $error("trade ids have wrong parity");

    a_non_trade_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_payload.kind != lob_pkg::KIND_TRADE |-> res_payload.last)
        else $error("single result without last");

endmodule

bind limit_order_book_matcher lob_checker u_lob_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_payload (res.payload)
);

FILE: dv/limit_order_book_matcher_test.sv
`timescale 1ns / 100ps

module limit_order_book_matcher_test;

    logic clk;
    logic rst_n;
    lob_req_if req ();
    lob_res_if res ();

    limit_order_book_matcher DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .res(res.source)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // predictor state
    logic [31:0] bid_px [lob_pkg::BOOK_DEPTH];
    logic [23:0] bid_qty [lob_pkg::BOOK_DEPTH];
    logic [15:0] bid_oid [lob_pkg::BOOK_DEPTH];
    int          bid_n;
    logic [31:0] ask_px [lob_pkg::BOOK_DEPTH];
    logic [23:0] ask_qty [lob_pkg::BOOK_DEPTH];
    logic [15:0] ask_oid [lob_pkg::BOOK_DEPTH];
    int          ask_n;
    logic [15:0] next_buy_id;
    logic [15:0] next_sell_id;

    lob_pkg::result_t expected_results [$];
    int          error_count;
    int          request_count;
    int          result_count;
    int          trade_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;

    function automatic lob_pkg::result_t make_result(lob_pkg::kind_t k, lob_pkg::status_t s,
                                                     logic [15:0] aid, logic [15:0] b,
                                                     logic [15:0] a, logic [23:0] q,
                                                     logic l);
        lob_pkg::result_t r;
        r.kind = k;
        r.status = s;
        r.assigned_id = aid;
        r.buy_id = b;
        r.sell_id = a;
        r.traded_amount = q;
        r.last = l;
        return r;
    endfunction

    task automatic drop_bid(int pos);
        for (int i = pos; i + 1 < bid_n; i++)
        begin
            bid_px[i] = bid_px[i + 1];
            bid_qty[i] = bid_qty[i + 1];
            bid_oid[i] = bid_oid[i + 1];
        end
        bid_n--;
    endtask

    task automatic drop_ask(int pos);
        for (int i = pos; i + 1 < ask_n; i++)
        begin
            ask_px[i] = ask_px[i + 1];
            ask_qty[i] = ask_qty[i + 1];
            ask_oid[i] = ask_oid[i + 1];
        end
        ask_n--;
    endtask

    task automatic predict_book(lob_pkg::request_t r);
        int pos;
        int n;
        int at;
        logic [15:0] nid;
        logic [23:0] q;
        logic even;
        even = ~r.order_id[0];
        case (lob_pkg::mode_t'(r.mode))
            lob_pkg::MODE_ADD:
            begin
                if (r.side)
                begin
                    if (bid_n >= lob_pkg::BOOK_DEPTH)
                    begin
                        expected_results.push_back(make_result(lob_pkg::KIND_ADD_ACK,
                            lob_pkg::STATUS_FULL, 16'd0, 16'd0, 16'd0, 24'd0, 1'b1));
                        return;
                    end
                    next_buy_id = next_buy_id + 16'd2;
                    nid = next_buy_id;
                    pos = bid_n;
                    for (int i = 0; i < bid_n; i++)
                        if (r.limit_price > bid_px[i])
                        begin
                            pos = i;
                            break;
                        end
                    for (int i = bid_n; i > pos; i--)
                    begin
                        bid_px[i] = bid_px[i - 1];
                        bid_qty[i] = bid_qty[i - 1];
                        bid_oid[i] = bid_oid[i - 1];
                    end
                    bid_px[pos] = r.limit_price;
                    bid_qty[pos] = r.amount;
                    bid_oid[pos] = nid;
                    bid_n++;
                end
                else
                begin
                    if (ask_n >= lob_pkg::BOOK_DEPTH)
                    begin
                        expected_results.push_back(make_result(lob_pkg::KIND_ADD_ACK,
                            lob_pkg::STATUS_FULL, 16'd0, 16'd0, 16'd0, 24'd0, 1'b1));
                        return;
                    end
                    next_sell_id = next_sell_id + 16'd2;
                    nid = next_sell_id;
                    pos = ask_n;
                    for (int i = 0; i < ask_n; i++)
                        if (r.limit_price < ask_px[i])
                        begin
                            pos = i;
                            break;
                        end
                    for (int i = ask_n; i > pos; i--)
                    begin
                        ask_px[i] = ask_px[i - 1];
                        ask_qty[i] = ask_qty[i - 1];
                        ask_oid[i] = ask_oid[i - 1];
                    end
                    ask_px[pos] = r.limit_price;
                    ask_qty[pos] = r.amount;
                    ask_oid[pos] = nid;
                    ask_n++;
                end
                expected_results.push_back(make_result(lob_pkg::KIND_ADD_ACK,
                    lob_pkg::STATUS_OK, nid, 16'd0, 16'd0, 24'd0, 1'b1));
            end
            lob_pkg::MODE_CHANGE, lob_pkg::MODE_REMOVE:
            begin
                at = -1;
                if (even)
                begin
                    for (int i = 0; i < bid_n; i++)
                        if (bid_oid[i] == r.order_id)
                        begin
                            at = i;
                            break;
                        end
                end
                else
                begin
                    for (int i = 0; i < ask_n; i++)
                        if (ask_oid[i] == r.order_id)
                        begin
                            at = i;
                            break;
                        end
                end
                if (at < 0)
                    expected_results.push_back(make_result(lob_pkg::kind_t'({1'b0, r.mode}),
                        lob_pkg::STATUS_NOT_FOUND, 16'd0, 16'd0, 16'd0, 24'd0, 1'b1));
                else
                begin
                    if (r.mode == lob_pkg::MODE_CHANGE)
                    begin
                        if (even)
                            bid_qty[at] = r.amount;
                        else
                            ask_qty[at] = r.amount;
                    end
                    else if (even)
                        drop_bid(at);
                    else
                        drop_ask(at);
                    expected_results.push_back(make_result(lob_pkg::kind_t'({1'b0, r.mode}),
                        lob_pkg::STATUS_OK, 16'd0, 16'd0, 16'd0, 24'd0, 1'b1));
                end
            end
            default:
            begin
                n = 0;
                while (bid_n > 0 && ask_n > 0 && n < 31 && bid_px[0] >= ask_px[0])
                begin
                    q = (bid_qty[0] < ask_qty[0]) ? bid_qty[0] : ask_qty[0];
                    expected_results.push_back(make_result(lob_pkg::KIND_TRADE,
                        lob_pkg::STATUS_OK, 16'd0, bid_oid[0], ask_oid[0], q, 1'b0));
                    n++;
                    trade_count++;
                    if (bid_qty[0] > ask_qty[0])
                    begin
                        bid_qty[0] = bid_qty[0] - ask_qty[0];
                        drop_ask(0);
                    end
                    else if (ask_qty[0] > bid_qty[0])
                    begin
                        ask_qty[0] = ask_qty[0] - bid_qty[0];
                        drop_bid(0);
                    end
                    else
                    begin
                        drop_bid(0);
                        drop_ask(0);
                    end
                end
                if (n == 0)
                    expected_results.push_back(make_result(lob_pkg::KIND_NO_TRADE,
                        lob_pkg::STATUS_OK, 16'd0, 16'd0, 16'd0, 24'd0, 1'b1));
                else
                    expected_results[$].last = 1'b1;
            end
        endcase
    endtask

    task automatic send_request(logic [1:0] m, logic s, logic [31:0] p, logic [23:0] a,
                                logic [15:0] id);
        lob_pkg::request_t r;
        r.mode = m;
        r.side = s;
        r.limit_price = p;
        r.amount = a;
        r.order_id = id;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.payload <= r;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_book(r);
        request_count++;
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * lob_pkg::BOOK_DEPTH + 8)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_price();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom();
            default: return 32'd1000 + 32'($urandom_range(20));
        endcase
    endfunction

    function automatic logic [23:0] pick_amount();
        case ($urandom_range(9))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'($urandom());
            default: return 24'($urandom_range(1, 50));
        endcase
    endfunction

    // pick an id that mostly hits a resting order
    function automatic logic [15:0] pick_id();
        int k;
        k = $urandom_range(9);
        if (k < 4 && bid_n > 0)
            return bid_oid[$urandom_range(bid_n - 1)];
        if (k < 8 && ask_n > 0)
            return ask_oid[$urandom_range(ask_n - 1)];
        return 16'($urandom());
    endfunction

    task automatic test_directed();
        send_request(lob_pkg::MODE_MATCH, 1'b0, 32'd0, 24'd0, 16'd0);
        send_request(lob_pkg::MODE_CHANGE, 1'b0, 32'd0, 24'd5, 16'd2);
        send_request(lob_pkg::MODE_REMOVE, 1'b0, 32'd0, 24'd0, 16'd1);
        send_request(lob_pkg::MODE_ADD, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF, 16'hFFFF);
        send_request(lob_pkg::MODE_ADD, 1'b0, 32'd0, 24'd0, 16'd0);
        send_request(lob_pkg::MODE_ADD, 1'b1, 32'd500, 24'd10, 16'd0);
        send_request(lob_pkg::MODE_ADD, 1'b1, 32'd500, 24'd7, 16'd0);
        send_request(lob_pkg::MODE_ADD, 1'b0, 32'd400, 24'd10, 16'd0);
        send_request(lob_pkg::MODE_ADD, 1'b0, 32'd600, 24'd3, 16'd0);
        send_request(lob_pkg::MODE_CHANGE, 1'b0, 32'd0, 24'd4, 16'd4);
        send_request(lob_pkg::MODE_REMOVE, 1'b0, 32'd0, 24'd0, 16'd6);
        send_request(lob_pkg::MODE_REMOVE, 1'b0, 32'd0, 24'd0, 16'd6);
        send_request(lob_pkg::MODE_MATCH, 1'b0, 32'd0, 24'd0, 16'd0);
        send_request(lob_pkg::MODE_MATCH, 1'b0, 32'd0, 24'd0, 16'd0);
        send_request(lob_pkg::MODE_ADD, 1'b0, 32'd1, 24'd9, 16'd0);
        send_request(lob_pkg::MODE_MATCH, 1'b0, 32'd0, 24'd0, 16'd0);
        for (int i = 0; i < 6; i++)
            send_request(lob_pkg::MODE_ADD, 1'b1, 32'd10 + 32'(i), 24'd5, 16'd0);
        send_request(lob_pkg::MODE_MATCH, 1'b0, 32'd0, 24'd0, 16'd0);
        wait_drained();
    endtask

    // fill both sides past full, then two matches; the first clears as much as it can
    task automatic test_full_books();
        for (int i = 0; i < lob_pkg::BOOK_DEPTH + 2; i++)
            send_request(lob_pkg::MODE_ADD, 1'b1, 32'd2000 + 32'($urandom_range(3)),
                         24'($urandom_range(1, 9)), 16'd0);
        for (int i = 0; i < lob_pkg::BOOK_DEPTH + 2; i++)
            send_request(lob_pkg::MODE_ADD, 1'b0, 32'd1990 + 32'($urandom_range(3)),
                         24'($urandom_range(1, 9)), 16'd0);
        send_request(lob_pkg::MODE_MATCH, 1'b0, 32'd0, 24'd0, 16'd0);
        send_request(lob_pkg::MODE_MATCH, 1'b0, 32'd0, 24'd0, 16'd0);
        wait_drained();
    endtask

    // receiver holds off while adds keep coming, so the block backs up
    task automatic test_back_pressure();
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            send_request(lob_pkg::MODE_ADD, i[0], pick_price(), pick_amount(), 16'd0);
        wait_drained();
    endtask

    task automatic test_random(int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 45)
                send_request(lob_pkg::MODE_ADD, 1'($urandom_range(1)), pick_price(),
                             pick_amount(), 16'($urandom()));
            else if (k < 60)
                send_request(lob_pkg::MODE_CHANGE, 1'($urandom_range(1)), $urandom(),
                             pick_amount(), pick_id());
            else if (k < 75)
                send_request(lob_pkg::MODE_REMOVE, 1'($urandom_range(1)), $urandom(),
                             24'($urandom()), pick_id());
            else
                send_request(lob_pkg::MODE_MATCH, 1'($urandom_range(1)), $urandom(),
                             24'($urandom()), 16'($urandom()));
        end
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.payload = '0;
        bid_n = 0;
        ask_n = 0;
        next_buy_id = 16'd0;
        next_sell_id = 16'd1;
        error_count = 0;
        request_count = 0;
        result_count = 0;
        trade_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_books();
        test_back_pressure();
        test_random(87);
        send_idle_pct = 67;
        test_random(87);
        send_idle_pct = 0;
        recv_stall_pct = 67;
        test_random(87);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        test_random(87);
        send_idle_pct = 0;
        recv_stall_pct = 0;

        $display("covered %0d requests, %0d results, %0d trades", request_count,
                 result_count, trade_count);
        $display("add, change, remove, match, full books, back pressure and idling");
        if (error_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // long receiver hold-off counted here
    always @(posedge clk)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else if (hold_off)
        begin
            res.ready <= 1'b0;
            repeat (400)
                @(posedge clk);
            hold_off = 1'b0;
        end
        else
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        lob_pkg::result_t exp_r;
        lob_pkg::result_t got;
        if (rst_n && res.valid && res.ready)
        begin
            got = res.payload;
            result_count++;
            if (expected_results.size() == 0)
            begin
                $error("result with none expected: kind %0d", got.kind);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got.kind !== exp_r.kind)
                begin
                    $error("kind expected %0d actual %0d", exp_r.kind, got.kind);
                    error_count++;
                end
                if (got.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, got.status);
                    error_count++;
                end
                if (got.assigned_id !== exp_r.assigned_id)
                begin
                    $error("assigned_id expected %0d actual %0d", exp_r.assigned_id,
                           got.assigned_id);
                    error_count++;
                end
                if (got.buy_id !== exp_r.buy_id)
                begin
                    $error("buy_id expected %0d actual %0d", exp_r.buy_id, got.buy_id);
                    error_count++;
                end
                if (got.sell_id !== exp_r.sell_id)
                begin
                    $error("sell_id expected %0d actual %0d", exp_r.sell_id, got.sell_id);
                    error_count++;
                end
                if (got.traded_amount !== exp_r.traded_amount)
                begin
                    $error("traded_amount expected %0d actual %0d", exp_r.traded_amount,
                           got.traded_amount);
                    error_count++;
                end
                if (got.last !== exp_r.last)
                begin
                    $error("last expected %0d actual %0d", exp_r.last, got.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 1000000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
